// ----- hw/rtl/gph_pkg.sv -----
// Shared types and constants for the generational handle pool.
`timescale 1ns / 1ps

package gph_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int GEN_BITS_DEF = 16;

    localparam int CMD_W        = 2;
    localparam int SLOT_INDEX_W = 8;
    localparam int SLOT_GEN_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE  = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_VALIDATE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

endpackage

// ----- hw/rtl/gph_if.sv -----
// Valid/ready channel interfaces for the command items and the result items.
`timescale 1ns / 1ps

interface gph_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [gph_pkg::CMD_W-1:0]             cmd;
    logic [gph_pkg::SLOT_INDEX_W-1:0]      slot_index;
    logic [gph_pkg::SLOT_GEN_W-1:0]        slot_gen;
    logic                                  handle_set;

    modport source (output valid, cmd, slot_index, slot_gen, handle_set, input ready);
    modport sink   (input valid, cmd, slot_index, slot_gen, handle_set, output ready);
endinterface

interface gph_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  ok;
    logic [gph_pkg::SLOT_INDEX_W-1:0]      out_index;
    logic [gph_pkg::SLOT_GEN_W-1:0]        out_gen;

    modport source (output valid, ok, out_index, out_gen, input ready);
    modport sink   (input valid, ok, out_index, out_gen, output ready);
endinterface

// ----- hw/rtl/gph_mem.sv -----
// Synchronous single-port-read memory with per-entry written bits and a fixed reset image.
`timescale 1ns / 1ps

module gph_mem #(
    parameter int WIDTH      = gph_pkg::SLOT_GEN_W,
    parameter int DEPTH      = gph_pkg::CAPACITY_DEF,
    parameter bit INIT_INDEX = 1'b0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data
);
    import gph_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // An entry never written reads as its reset image.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else if (INIT_INDEX) begin
            o_rd_data = WIDTH'(r_rd_addr);
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// ----- hw/rtl/generational_handle_pool_top.sv -----
// Generational handle pool: free-index stack, generation memory and command sequencer.
//
// Usage: command items enter on i_in (cmd, slot_index, slot_gen, handle_set) and
// every command gives exactly one result item on o_out (ok, out_index, out_gen).
// Acquire pops a free slot and returns its index and generation; release checks
// the generation, bumps it and pushes the slot back; validate only reports ok.
// Failed or non-acquire commands return zero index and generation.
//
// Timing: one command is worked on at a time. For release, validate and the
// unused command the accepted item passes S_RD1 and S_DONE before the result
// item is shown on o_out; acquire also passes S_RD2, since the generation read
// depends on the index popped from the stack. A new command is taken only after
// the result of the last one is loaded into the output register.
// Each generation entry also holds the slot's active mark above the generation.
//
// Reset (synchronous, active low) empties the pool: every slot is free, every
// generation reads as zero and no slot is active. No clearing pass is needed.
// A result that the receiver does not take waits in the output register; one
// more command is still accepted and worked on, then i_in.ready stays low
// until the output register frees up.
`timescale 1ns / 1ps

module generational_handle_pool_top #(
    parameter int CAPACITY = gph_pkg::CAPACITY_DEF,
    parameter int GEN_BITS = gph_pkg::GEN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gph_in_if.sink    i_in,
    gph_out_if.source o_out
);
    import gph_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (GEN_BITS > SLOT_GEN_W) ? GEN_BITS : SLOT_GEN_W;
    localparam int GM_W  = GEN_BITS + 1;

    localparam logic [SLOT_INDEX_W:0] IDX_LIM = (SLOT_INDEX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0]      CNT_CAP = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [SLOT_INDEX_W-1:0] r_idx, n_idx;
    logic [SLOT_GEN_W-1:0]   r_gen, n_gen;
    logic                    r_set, n_set;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic                    r_res_ok, n_res_ok;
    logic [IDX_W-1:0]        r_res_index, n_res_index;
    logic [SLOT_GEN_W-1:0]   r_res_gen, n_res_gen;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_ok, n_out_ok;
    logic [SLOT_INDEX_W-1:0] r_out_index, n_out_index;
    logic [SLOT_GEN_W-1:0]   r_out_gen, n_out_gen;

    logic                    accept;
    logic                    idx_ok;
    logic                    count_lt;
    logic [CNT_W-1:0]        count_dec;
    logic                    gen_match;
    logic [GEN_BITS-1:0]     gen_inc;
    logic [GEN_BITS-1:0]     rd_gen;
    logic                    rd_active;

    logic                    stk_rd_en, stk_wr_en;
    logic [IDX_W-1:0]        stk_rd_addr, stk_wr_addr, stk_rd_data, stk_wr_data;
    logic                    gen_rd_en, gen_wr_en;
    logic [IDX_W-1:0]        gen_rd_addr, gen_wr_addr;
    logic [GM_W-1:0]         gen_rd_data, gen_wr_data;

    gph_mem #(
        .WIDTH      (IDX_W),
        .DEPTH      (CAPACITY),
        .INIT_INDEX (1'b1)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data)
    );

    gph_mem #(
        .WIDTH      (GM_W),
        .DEPTH      (CAPACITY),
        .INIT_INDEX (1'b0)
    ) u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (gen_rd_en),
        .i_rd_addr (gen_rd_addr),
        .o_rd_data (gen_rd_data),
        .i_wr_en   (gen_wr_en),
        .i_wr_addr (gen_wr_addr),
        .i_wr_data (gen_wr_data)
    );

    assign accept    = i_in.valid && (r_state == S_IDLE);
    assign idx_ok    = {1'b0, r_idx} < IDX_LIM;
    assign count_lt  = r_count < CNT_CAP;
    assign count_dec = r_count - CNT_W'(1);
    assign rd_gen    = gen_rd_data[GEN_BITS-1:0];
    assign rd_active = gen_rd_data[GEN_BITS];
    assign gen_match = CMP_W'(rd_gen) == CMP_W'(r_gen);
    assign gen_inc   = rd_gen + GEN_BITS'(1);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_gen       = r_gen;
        n_set       = r_set;
        n_count     = r_count;
        n_slot      = r_slot;
        n_res_ok    = r_res_ok;
        n_res_index = r_res_index;
        n_res_gen   = r_res_gen;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_index = r_out_index;
        n_out_gen   = r_out_gen;

        // The stack is read at the top on every accepted item while a slot is
        // free; the generation memory at the handle index, or at the popped slot.
        stk_rd_en   = accept && count_lt;
        stk_rd_addr = r_count[IDX_W-1:0];
        stk_wr_en   = 1'b0;
        stk_wr_addr = count_dec[IDX_W-1:0];
        stk_wr_data = r_idx[IDX_W-1:0];
        gen_rd_en   = accept;
        gen_rd_addr = i_in.slot_index[IDX_W-1:0];
        gen_wr_en   = 1'b0;
        gen_wr_addr = r_idx[IDX_W-1:0];
        gen_wr_data = {1'b0, gen_inc};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = t_cmd'(i_in.cmd);
                    n_idx   = i_in.slot_index;
                    n_gen   = i_in.slot_gen;
                    n_set   = i_in.handle_set;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_res_ok    = 1'b0;
                n_res_index = '0;
                n_res_gen   = '0;
                n_state     = S_DONE;
                case (r_cmd)
                    CMD_ACQUIRE: begin
                        if (count_lt) begin
                            n_slot      = stk_rd_data;
                            gen_rd_en   = 1'b1;
                            gen_rd_addr = stk_rd_data;
                            n_state     = S_RD2;
                        end
                    end
                    CMD_RELEASE: begin
                        // Clears the active mark and bumps the generation in one write.
                        if (idx_ok && (r_count != '0) && gen_match) begin
                            gen_wr_en = 1'b1;
                            stk_wr_en = 1'b1;
                            n_count   = count_dec;
                            n_res_ok  = 1'b1;
                        end
                    end
                    CMD_VALIDATE: begin
                        n_res_ok = r_set && idx_ok && gen_match && rd_active;
                    end
                    default: begin
                        n_res_ok = 1'b0;
                    end
                endcase
            end
            S_RD2: begin
                gen_wr_en   = 1'b1;
                gen_wr_addr = r_slot;
                gen_wr_data = {1'b1, rd_gen};
                n_count     = r_count + CNT_W'(1);
                n_res_ok    = 1'b1;
                n_res_index = r_slot;
                n_res_gen   = SLOT_GEN_W'(rd_gen);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_index = SLOT_INDEX_W'(r_res_index);
                    n_out_gen   = r_res_gen;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_gen       <= n_gen;
        r_set       <= n_set;
        r_slot      <= n_slot;
        r_res_ok    <= n_res_ok;
        r_res_index <= n_res_index;
        r_res_gen   <= n_res_gen;
        r_out_ok    <= n_out_ok;
        r_out_index <= n_out_index;
        r_out_gen   <= n_out_gen;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.ok        = r_out_ok;
    assign o_out.out_index = r_out_index;
    assign o_out.out_gen   = r_out_gen;

endmodule

// ----- hw/rtl/gph_checker.sv -----
// Port-level assertions for the generational handle pool, bound to the top level.
`timescale 1ns / 1ps

module gph_port_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_out_ok,
    input logic [gph_pkg::SLOT_INDEX_W-1:0]  i_out_index,
    input logic [gph_pkg::SLOT_GEN_W-1:0]    i_out_gen
);
    import gph_pkg::*;

    // A held result keeps its fields until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_ok) && $stable(i_out_index) && $stable(i_out_gen))
        else $error("result item changed while stalled");

    // Failed commands report zero index and generation.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> (i_out_index == '0) && (i_out_gen == '0))
        else $error("failed result carries nonzero fields");

    // Items are worked on one at a time: ready drops right after acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted back to back");

    // A result is never shown straight on acceptance; it first passes the read states.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared too early");

endmodule

bind generational_handle_pool_top gph_port_checker u_gph_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ok    (o_out.ok),
    .i_out_index (o_out.out_index),
    .i_out_gen   (o_out.out_gen)
);
